@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/pha_pkg.sv @@
// ----------------------------------------------------------------------------
// pha_pkg
// Types, codes and defaults shared by the page hole fit allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pha_pkg;

  // Owner id width, fixed by the request field
  localparam int ID_BITS = 8;

  // Defaults for top-level parameters
  localparam int DEF_NUM_PAGES = 32;
  localparam int DEF_PAGE_KB   = 4;

  // Request codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_KILL  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_RUNNING = 2'd1;
  localparam logic [1:0] STS_NOMEM   = 2'd2;
  localparam logic [1:0] STS_NOPROG  = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [ID_BITS-1:0] owner_id;
    logic [7:0]         size_kb;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] page_count;
    logic [4:0] first_page;
    logic [4:0] fragment_count;
  } out_item_t;

  // Ring control from the sequencer to the cell chain
  typedef struct packed {
    logic               shift;
    logic [ID_BITS-1:0] tail_data;
  } ring_ctl_t;

endpackage

@@ hdl/pha_cell.sv @@
// ----------------------------------------------------------------------------
// pha_cell
// One page entry of the owner ring; takes its neighbor's value on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pha_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic [pha_pkg::ID_BITS-1:0] d_in,
  output logic [pha_pkg::ID_BITS-1:0] q
);
  import pha_pkg::*;

  logic [ID_BITS-1:0] owner_r;

  // Owner register, cleared to free on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r <= '0;
    end else if (shift_en) begin
      owner_r <= d_in;
    end
  end

  assign q = owner_r;

endmodule

@@ hdl/pha_ctrl.sv @@
// ----------------------------------------------------------------------------
// pha_ctrl
// Sequencer: scans the owner ring once to find holes and ids, then rotates
// it once more to apply the add or kill and count used runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pha_ctrl #(
  parameter int NUM_PAGES = pha_pkg::DEF_NUM_PAGES,
  parameter int PAGE_KB   = pha_pkg::DEF_PAGE_KB
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pha_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pha_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data,
  input  logic [pha_pkg::ID_BITS-1:0] head,
  output pha_pkg::ring_ctl_t          ring
);
  import pha_pkg::*;

  localparam int CNT_W  = $clog2(NUM_PAGES);
  localparam int MAX_KB = NUM_PAGES * PAGE_KB;
  localparam int KB_W   = $clog2(MAX_KB + 1);
  localparam int CMP_W  = (KB_W > 8) ? KB_W : 8;
  localparam int PG_W   = $clog2(NUM_PAGES + 1);

  localparam logic [CNT_W-1:0] LAST     = CNT_W'(NUM_PAGES - 1);
  localparam logic [CMP_W-1:0] STEP_KB  = CMP_W'(PAGE_KB);
  localparam logic [CMP_W-1:0] MAX_KB_C = CMP_W'(MAX_KB);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_DONE} state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [7:0]         size_r, size_nxt;
  logic               mode_r, mode_nxt;
  logic               present_r, present_nxt;
  logic [CMP_W-1:0]   run_kb_r, run_kb_nxt;
  logic [CNT_W-1:0]   run_start_r, run_start_nxt;
  logic               found_r, found_nxt;
  logic [CMP_W-1:0]   best_kb_r, best_kb_nxt;
  logic [CNT_W-1:0]   best_start_r, best_start_nxt;
  logic [CMP_W-1:0]   wkb_r, wkb_nxt;
  logic [PG_W-1:0]    pages_r, pages_nxt;
  logic [PG_W-1:0]    frag_r, frag_nxt;
  logic               prev_used_r, prev_used_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               head_free, last, do_eval, fits, better;
  logic [CMP_W-1:0]   size_ext, cur_kb, eval_kb;
  logic [CNT_W-1:0]   cur_start, eval_start;
  logic               add_ok, kill_en, wr_add, wr_kill, new_used;
  logic [ID_BITS-1:0] new_val;
  logic [1:0]         status_c;

  // Hole tracking on the entry at the ring head
  always_comb begin
    head_free  = (head == '0);
    last       = (cnt_r == LAST);
    size_ext   = CMP_W'(size_r);
    cur_kb     = run_kb_r + STEP_KB;
    cur_start  = (run_kb_r == '0) ? cnt_r : run_start_r;
    eval_kb    = head_free ? cur_kb : run_kb_r;
    eval_start = head_free ? cur_start : run_start_r;
    do_eval    = !head_free || last;
    fits       = (eval_kb != '0) && (eval_kb >= size_ext);
    better     = !found_r || (mode_r ? (eval_kb < best_kb_r) : (eval_kb > best_kb_r));
  end

  // Update of the entry at the ring head during the apply pass
  always_comb begin
    add_ok   = (op_r == OP_ADD) && !present_r && (size_ext <= MAX_KB_C) && found_r;
    kill_en  = (op_r == OP_KILL) && (id_r != '0);
    wr_add   = add_ok && (cnt_r >= best_start_r) && ((wkb_r == '0) || (wkb_r < size_ext));
    wr_kill  = kill_en && (head == id_r);
    new_val  = wr_add ? id_r : (wr_kill ? '0 : head);
    new_used = (new_val != '0);
  end

  // Result status
  always_comb begin
    unique case (op_r)
      OP_ADD: begin
        if (present_r) begin
          status_c = STS_RUNNING;
        end else if (!add_ok) begin
          status_c = STS_NOMEM;
        end else begin
          status_c = STS_OK;
        end
      end
      OP_KILL: begin
        status_c = (pages_r == '0) ? STS_NOPROG : STS_OK;
      end
      default: begin
        status_c = STS_OK;
      end
    endcase
  end

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    size_nxt       = size_r;
    mode_nxt       = cfg_valid ? cfg_data : mode_r;
    present_nxt    = present_r;
    run_kb_nxt     = run_kb_r;
    run_start_nxt  = run_start_r;
    found_nxt      = found_r;
    best_kb_nxt    = best_kb_r;
    best_start_nxt = best_start_r;
    wkb_nxt        = wkb_r;
    pages_nxt      = pages_r;
    frag_nxt       = frag_r;
    prev_used_nxt  = prev_used_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    ring.shift     = 1'b0;
    ring.tail_data = head;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_data.op;
          id_nxt         = in_data.owner_id;
          size_nxt       = in_data.size_kb;
          present_nxt    = (in_data.owner_id == '0);
          cnt_nxt        = '0;
          run_kb_nxt     = '0;
          run_start_nxt  = '0;
          found_nxt      = 1'b0;
          best_kb_nxt    = '0;
          best_start_nxt = '0;
          wkb_nxt        = '0;
          pages_nxt      = '0;
          frag_nxt       = '0;
          prev_used_nxt  = 1'b0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        ring.shift     = 1'b1;
        ring.tail_data = head;
        if (head == id_r) begin
          present_nxt = 1'b1;
        end
        if (do_eval && fits && better) begin
          found_nxt      = 1'b1;
          best_kb_nxt    = eval_kb;
          best_start_nxt = eval_start;
        end
        run_kb_nxt    = head_free ? cur_kb : '0;
        run_start_nxt = head_free ? cur_start : run_start_r;
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = S_APPLY;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_APPLY: begin
        ring.shift     = 1'b1;
        ring.tail_data = new_val;
        if (wr_add) begin
          wkb_nxt = wkb_r + STEP_KB;
        end
        if (wr_add || wr_kill) begin
          pages_nxt = pages_r + 1'b1;
        end
        if (new_used && !prev_used_r) begin
          frag_nxt = frag_r + 1'b1;
        end
        prev_used_nxt = new_used;
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.status         = status_c;
          out_nxt.page_count     = 6'(pages_r);
          out_nxt.first_page     = add_ok ? 5'(best_start_r) : 5'd0;
          out_nxt.fragment_count = 5'(frag_r);
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    size_r       <= size_nxt;
    present_r    <= present_nxt;
    run_kb_r     <= run_kb_nxt;
    run_start_r  <= run_start_nxt;
    found_r      <= found_nxt;
    best_kb_r    <= best_kb_nxt;
    best_start_r <= best_start_nxt;
    wkb_r        <= wkb_nxt;
    pages_r      <= pages_nxt;
    frag_r       <= frag_nxt;
    prev_used_r  <= prev_used_nxt;
    out_r        <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  `ASSERT_CLK(a_accept_leaves_idle, (in_valid && in_ready) |=> (state_r == S_SCAN), "accepted transfer did not start a scan")
  `ASSERT_CLK(a_result_after_apply, $rose(out_valid_r) |-> ($past(state_r) == S_DONE), "result raised outside done state")
  `ASSERT_CLK(a_fail_no_first_page, (out_valid_r && (out_r.status != STS_OK)) |-> (out_r.first_page == 5'd0), "failed request reports a first page")
  `ASSERT_ALWAYS(a_idle_counter_clear, (state_r == S_IDLE) |-> (cnt_r == '0), "page counter not cleared in idle")

endmodule

@@ hdl/page_hole_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// page_hole_fit_allocator: page map allocator, worst or best fit
// From the input transfer to the result transfer: one full rotation of the owner
// cell ring to scan, one to apply, then the result is registered. A new request is
// taken only after the previous result is registered; a result the receiver has
// not taken holds the next one.
// Reset (synchronous, rst_n low) frees all pages, selects worst fit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_hole_fit_allocator #(
  parameter int NUM_PAGES = pha_pkg::DEF_NUM_PAGES,
  parameter int PAGE_KB   = pha_pkg::DEF_PAGE_KB
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pha_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pha_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import pha_pkg::*;

  logic [ID_BITS-1:0] owner_q [NUM_PAGES];
  ring_ctl_t          ring;

  // Sequencer
  pha_ctrl #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_KB   (PAGE_KB)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .head      (owner_q[0]),
    .ring      (ring)
  );

  // Owner ring: each cell takes the next one's value, the tail takes the head entry back, updated during apply
  for (genvar k = 0; k < NUM_PAGES; k++) begin : g_cell
    logic [ID_BITS-1:0] d_in;
    if (k == NUM_PAGES - 1) begin : g_tail
      assign d_in = ring.tail_data;
    end else begin : g_mid
      assign d_in = owner_q[k+1];
    end
    pha_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (ring.shift),
      .d_in     (d_in),
      .q        (owner_q[k])
    );
  end

endmodule
